/* hdl/scc_pkg.sv */
package scc_pkg;

    localparam int DistW  = 12;
    localparam int SpeedW = 7;
    localparam int TickW  = 7;
    localparam int CountW = 8;
    localparam int MotorW = 8;
    localparam int NumDist = 3;
    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 12;

    localparam logic [SpeedW-1:0] SpeedMax = 7'd100;

    typedef enum logic [CfgIdxW-1:0] {
        REG_DETECT_THRESHOLD  = 3'd0,
        REG_SEARCH_SPEED      = 3'd1,
        REG_ATTACK_SPEED      = 3'd2,
        REG_ATTACK_SIDE_SPEED = 3'd3,
        REG_BACKUP_SPEED      = 3'd4,
        REG_TURN_SPEED        = 3'd5,
        REG_BACKUP_TICKS      = 3'd6,
        REG_TURN_TICKS        = 3'd7
    } t_reg_idx;

    localparam logic [DistW-1:0]  RstDetectThreshold = 12'd300;
    localparam logic [SpeedW-1:0] RstSearchSpeed     = 7'd40;
    localparam logic [SpeedW-1:0] RstAttackSpeed     = 7'd100;
    localparam logic [SpeedW-1:0] RstAttackSideSpeed = 7'd60;
    localparam logic [SpeedW-1:0] RstBackupSpeed     = 7'd80;
    localparam logic [SpeedW-1:0] RstTurnSpeed       = 7'd70;
    localparam logic [TickW-1:0]  RstBackupTicks     = 7'd30;
    localparam logic [TickW-1:0]  RstTurnTicks       = 7'd20;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_SEARCH = 2'd1,
        PH_ATTACK = 2'd2,
        PH_EVADE  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        TGT_NONE  = 2'd0,
        TGT_FRONT = 2'd1,
        TGT_LEFT  = 2'd2,
        TGT_RIGHT = 2'd3
    } t_target;

    typedef struct packed {
        logic             hit;
        logic [DistW-1:0] reading;
    } t_lane_res;

    function automatic logic [SpeedW-1:0] sat_speed(input logic [SpeedW-1:0] v);
        return (v > SpeedMax) ? SpeedMax : v;
    endfunction

endpackage

/* hdl/scc_tick_if.sv */
interface scc_tick_if;
    logic                      valid;
    logic                      ready;
    logic                      combat_enable;
    logic [scc_pkg::DistW-1:0] dist_front;
    logic [scc_pkg::DistW-1:0] dist_left;
    logic [scc_pkg::DistW-1:0] dist_right;
    logic                      edge_left;
    logic                      edge_right;

    modport source (
        output valid, combat_enable, dist_front, dist_left, dist_right, edge_left, edge_right,
        input  ready
    );
    modport sink (
        input  valid, combat_enable, dist_front, dist_left, dist_right, edge_left, edge_right,
        output ready
    );
endinterface

/* hdl/scc_cmd_if.sv */
interface scc_cmd_if;
    logic                              valid;
    logic                              ready;
    logic                              command_valid;
    logic                              brake;
    logic signed [scc_pkg::MotorW-1:0] left_speed;
    logic signed [scc_pkg::MotorW-1:0] right_speed;
    logic                              beep;
    logic [1:0]                        phase;

    modport source (
        output valid, command_valid, brake, left_speed, right_speed, beep, phase,
        input  ready
    );
    modport sink (
        input  valid, command_valid, brake, left_speed, right_speed, beep, phase,
        output ready
    );
endinterface

/* hdl/scc_lane.sv */
module scc_lane (
    input  logic [scc_pkg::DistW-1:0] i_dist,
    input  logic [scc_pkg::DistW-1:0] i_threshold,
    output scc_pkg::t_lane_res        o_res
);
    // a reading qualifies when it is present and strictly below the limit
    always_comb begin
        o_res.hit     = (i_dist != '0) && (i_dist < i_threshold);
        o_res.reading = i_dist;
    end
endmodule

/* hdl/scc_merge.sv */
module scc_merge (
    input  scc_pkg::t_lane_res [scc_pkg::NumDist-1:0] i_lanes,
    output scc_pkg::t_target                          o_target
);
    // nearest wins, ties go to the earlier sensor
    always_comb begin
        logic [scc_pkg::DistW-1:0] best;
        best     = i_lanes[0].reading;
        o_target = scc_pkg::TGT_NONE;
        if (i_lanes[0].hit) begin
            o_target = scc_pkg::TGT_FRONT;
        end
        if (i_lanes[1].hit && (o_target == scc_pkg::TGT_NONE || i_lanes[1].reading < best)) begin
            o_target = scc_pkg::TGT_LEFT;
            best     = i_lanes[1].reading;
        end
        if (i_lanes[2].hit && (o_target == scc_pkg::TGT_NONE || i_lanes[2].reading < best)) begin
            o_target = scc_pkg::TGT_RIGHT;
        end
    end
endmodule

/* hdl/sumo_combat_controller_unit.sv */
// Sumo combat controller: one control tick in, one motor command item out. A tick is
// taken every clock cycle unless the output is stalled; its command appears in the output
// register on the next cycle, and a new tick is taken while that command waits as long as
// the sink takes it in the same cycle. The search/attack/evade state and the evade counter
// are updated in the cycle a tick is accepted. Three compare lanes qualify the front, left
// and right readings against detect_threshold in parallel and a merge stage picks the
// nearest. Configuration writes take effect on the next tick.
module sumo_combat_controller_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [scc_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [scc_pkg::CfgDataW-1:0] i_cfg_data,
    scc_tick_if.sink                     i_tick,
    scc_cmd_if.source                    o_cmd
);
    logic [scc_pkg::DistW-1:0]  r_threshold;
    logic [scc_pkg::SpeedW-1:0] r_search_speed;
    logic [scc_pkg::SpeedW-1:0] r_attack_speed;
    logic [scc_pkg::SpeedW-1:0] r_side_speed;
    logic [scc_pkg::SpeedW-1:0] r_backup_speed;
    logic [scc_pkg::SpeedW-1:0] r_turn_speed;
    logic [scc_pkg::TickW-1:0]  r_backup_ticks;
    logic [scc_pkg::TickW-1:0]  r_turn_ticks;

    scc_pkg::t_phase             r_state, n_state;
    logic [scc_pkg::CountW-1:0]  r_count, n_count;

    logic                              r_valid;
    logic                              r_command_valid, n_command_valid;
    logic                              r_brake, n_brake;
    logic signed [scc_pkg::MotorW-1:0] r_left, n_left;
    logic signed [scc_pkg::MotorW-1:0] r_right, n_right;
    logic                              r_beep, n_beep;

    logic                                      accept;
    scc_pkg::t_lane_res [scc_pkg::NumDist-1:0] lanes;
    logic [scc_pkg::DistW-1:0]                 dists [scc_pkg::NumDist];
    scc_pkg::t_target                          target;

    assign i_tick.ready = i_rst_n && (!r_valid || o_cmd.ready);
    assign accept       = i_tick.valid && i_tick.ready;

    assign dists[0] = i_tick.dist_front;
    assign dists[1] = i_tick.dist_left;
    assign dists[2] = i_tick.dist_right;

    for (genvar g = 0; g < scc_pkg::NumDist; g++) begin : g_lane
        scc_lane u_lane (
            .i_dist      (dists[g]),
            .i_threshold (r_threshold),
            .o_res       (lanes[g])
        );
    end

    scc_merge u_merge (
        .i_lanes  (lanes),
        .o_target (target)
    );

    function automatic logic signed [scc_pkg::MotorW-1:0] pos(
        input logic [scc_pkg::SpeedW-1:0] v
    );
        return $signed({1'b0, scc_pkg::sat_speed(v)});
    endfunction

    function automatic logic signed [scc_pkg::MotorW-1:0] neg(
        input logic [scc_pkg::SpeedW-1:0] v
    );
        return -$signed({1'b0, scc_pkg::sat_speed(v)});
    endfunction

    always_comb begin
        logic                       edge_seen;
        logic [scc_pkg::CountW-1:0] backup_cnt;
        logic [scc_pkg::CountW-1:0] total;
        edge_seen       = i_tick.edge_left || i_tick.edge_right;
        backup_cnt      = scc_pkg::CountW'(r_backup_ticks);
        total           = scc_pkg::CountW'(r_backup_ticks) + scc_pkg::CountW'(r_turn_ticks);
        n_state         = r_state;
        n_count         = r_count;
        n_command_valid = 1'b0;
        n_brake         = 1'b0;
        n_left          = '0;
        n_right         = '0;
        n_beep          = 1'b0;
        if (!i_tick.combat_enable) begin
            n_state         = scc_pkg::PH_IDLE;
            n_count         = '0;
            n_command_valid = 1'b1;
            n_brake         = 1'b1;
        end else begin
            unique case (r_state)
                scc_pkg::PH_IDLE, scc_pkg::PH_SEARCH: begin
                    n_state         = scc_pkg::PH_SEARCH;
                    n_command_valid = 1'b1;
                    n_left          = neg(r_search_speed);
                    n_right         = pos(r_search_speed);
                    if (target != scc_pkg::TGT_NONE) begin
                        n_state = scc_pkg::PH_ATTACK;
                        n_beep  = 1'b1;
                    end
                    if (edge_seen) begin
                        n_state = scc_pkg::PH_EVADE;
                        n_count = '0;
                    end
                end
                scc_pkg::PH_ATTACK: begin
                    if (edge_seen) begin
                        n_state = scc_pkg::PH_EVADE;
                        n_count = '0;
                    end else if (target == scc_pkg::TGT_NONE) begin
                        n_state = scc_pkg::PH_SEARCH;
                    end else begin
                        n_command_valid = 1'b1;
                        n_left          = pos(r_attack_speed);
                        n_right         = pos(r_attack_speed);
                        if (target == scc_pkg::TGT_LEFT) begin
                            n_left = pos(r_side_speed);
                        end else if (target == scc_pkg::TGT_RIGHT) begin
                            n_right = pos(r_side_speed);
                        end
                    end
                end
                scc_pkg::PH_EVADE: begin
                    if (r_count < backup_cnt) begin
                        n_command_valid = 1'b1;
                        n_left          = neg(r_backup_speed);
                        n_right         = neg(r_backup_speed);
                    end else if (r_count < total) begin
                        n_command_valid = 1'b1;
                        n_left          = neg(r_turn_speed);
                        n_right         = pos(r_turn_speed);
                    end
                    if (n_command_valid) begin
                        n_count = r_count + 1'b1;
                    end
                    if (n_count >= total) begin
                        n_state = scc_pkg::PH_SEARCH;
                        n_count = '0;
                    end
                end
                default: begin
                    n_state = scc_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold    <= scc_pkg::RstDetectThreshold;
            r_search_speed <= scc_pkg::RstSearchSpeed;
            r_attack_speed <= scc_pkg::RstAttackSpeed;
            r_side_speed   <= scc_pkg::RstAttackSideSpeed;
            r_backup_speed <= scc_pkg::RstBackupSpeed;
            r_turn_speed   <= scc_pkg::RstTurnSpeed;
            r_backup_ticks <= scc_pkg::RstBackupTicks;
            r_turn_ticks   <= scc_pkg::RstTurnTicks;
        end else if (i_cfg_we) begin
            unique case (scc_pkg::t_reg_idx'(i_cfg_idx))
                scc_pkg::REG_DETECT_THRESHOLD:  r_threshold    <= i_cfg_data;
                scc_pkg::REG_SEARCH_SPEED:      r_search_speed <= i_cfg_data[scc_pkg::SpeedW-1:0];
                scc_pkg::REG_ATTACK_SPEED:      r_attack_speed <= i_cfg_data[scc_pkg::SpeedW-1:0];
                scc_pkg::REG_ATTACK_SIDE_SPEED: r_side_speed   <= i_cfg_data[scc_pkg::SpeedW-1:0];
                scc_pkg::REG_BACKUP_SPEED:      r_backup_speed <= i_cfg_data[scc_pkg::SpeedW-1:0];
                scc_pkg::REG_TURN_SPEED:        r_turn_speed   <= i_cfg_data[scc_pkg::SpeedW-1:0];
                scc_pkg::REG_BACKUP_TICKS:      r_backup_ticks <= i_cfg_data[scc_pkg::TickW-1:0];
                scc_pkg::REG_TURN_TICKS:        r_turn_ticks   <= i_cfg_data[scc_pkg::TickW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scc_pkg::PH_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_state <= n_state;
                r_count <= n_count;
                r_valid <= 1'b1;
            end else if (o_cmd.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // output item payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_command_valid <= n_command_valid;
            r_brake         <= n_brake;
            r_left          <= n_left;
            r_right         <= n_right;
            r_beep          <= n_beep;
        end
    end

    assign o_cmd.valid         = r_valid;
    assign o_cmd.command_valid = r_command_valid;
    assign o_cmd.brake         = r_brake;
    assign o_cmd.left_speed    = r_left;
    assign o_cmd.right_speed   = r_right;
    assign o_cmd.beep          = r_beep;
    assign o_cmd.phase         = r_state;
endmodule

/* hdl/scc_checker.sv */
module scc_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              i_in_ready,
    input logic                              i_in_enable,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic                              i_command_valid,
    input logic                              i_brake,
    input logic signed [scc_pkg::MotorW-1:0] i_left,
    input logic signed [scc_pkg::MotorW-1:0] i_right,
    input logic                              i_beep,
    input logic [1:0]                        i_phase
);
    // disabled tick gives a brake item in idle
    a_disable_brakes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_in_enable |=>
            i_out_valid && i_command_valid && i_brake && i_phase == scc_pkg::PH_IDLE)
        else $error("disabled tick did not brake");

    a_quiet_speeds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_brake || !i_command_valid) |-> i_left == '0 && i_right == '0)
        else $error("nonzero speed with brake or no command");

    a_beep_attack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_beep |->
            i_command_valid && !i_brake &&
            (i_phase == scc_pkg::PH_ATTACK || i_phase == scc_pkg::PH_EVADE))
        else $error("beep outside a search hit");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_command_valid) && $stable(i_left) && $stable(i_right))
        else $error("stalled item changed");
endmodule

bind sumo_combat_controller_unit scc_checker u_scc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_tick.valid),
    .i_in_ready      (i_tick.ready),
    .i_in_enable     (i_tick.combat_enable),
    .i_out_valid     (o_cmd.valid),
    .i_out_ready     (o_cmd.ready),
    .i_command_valid (o_cmd.command_valid),
    .i_brake         (o_cmd.brake),
    .i_left          (o_cmd.left_speed),
    .i_right         (o_cmd.right_speed),
    .i_beep          (o_cmd.beep),
    .i_phase         (o_cmd.phase)
);
